// ===== rtl/core/bpsu_pkg.sv =====
// Package: constants, codes and types shared by the BMP pixel stream unpacker.
`default_nettype none

package bpsu_pkg;

   localparam int MAX_DIM    = 2048;
   localparam int DIM_W      = 12;   // width/height registers
   localparam int CNT_W      = 11;   // column and row counters
   localparam int ORIGIN_W   = 11;
   localparam int COORD_W    = 12;   // screen positions, wrap modulo 2^12
   localparam int BYTE_W     = 8;
   localparam int COLOR_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_MIRROR_X     = 3'd1,
      REG_IMAGE_HEIGHT = 3'd2,
      REG_BOTTOM_UP    = 3'd3,
      REG_HAS_ALPHA    = 3'd4,
      REG_ORIGIN_X     = 3'd5,
      REG_ORIGIN_Y     = 3'd6
   } csr_reg_type;

   typedef enum logic [1:0] {
      PH_BLUE  = 2'd0,
      PH_GREEN = 2'd1,
      PH_RED   = 2'd2,
      PH_ALPHA = 2'd3
   } phase_type;

   typedef struct packed {
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [COLOR_W-1:0] pixel_color;
      logic               image_done;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== rtl/core/bpsu_if.sv =====
// Interfaces: pixel byte request, pixel result and register write channels.
`default_nettype none

interface bpsu_req_if;
   logic                        valid;
   logic                        ready;
   logic [bpsu_pkg::BYTE_W-1:0] pixel_byte;

   modport source (output valid, output pixel_byte, input ready);
   modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface bpsu_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bpsu_pkg::COORD_W-1:0] pos_x;
   logic [bpsu_pkg::COORD_W-1:0] pos_y;
   logic [bpsu_pkg::COLOR_W-1:0] pixel_color;
   logic                         image_done;

   modport source (output valid, output pos_x, output pos_y, output pixel_color,
                   output image_done, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pixel_color,
                   input image_done, output ready);
endinterface

interface bpsu_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bpsu_pkg::CSR_IDX_W-1:0]  index;
   logic [bpsu_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bmp_pixel_stream_unpacker.sv =====
// BMP pixel stream unpacker: pixel array bytes in, positioned ARGB pixels out.
//
// req_ch carries one byte of the BMP pixel array per request, row padding
// included. Bytes come B, G, R (and A when has_alpha is set). The byte that
// completes a pixel produces one request on rsp_ch with the screen position,
// the packed ARGB color and image_done on the last pixel of the image; all
// other bytes (color bytes and pad bytes) produce nothing.
// csr_ch writes the geometry/format registers; it is always ready and should
// only be written while no pixel is in flight.
// Throughput: one byte per cycle while the queue has room. A completing byte's
// result is registered into the queue and offered on rsp_ch after older ones.
// They sit in a two-entry output queue, so req_ch keeps taking bytes while a
// result waits and stalls only when a stalled receiver holds both entries.
// Reset (synchronous, active high) empties the queue, clears the byte phase,
// color holds, counters and pad count, and loads register defaults:
// width 1, height 1, bottom_up 1, everything else 0.
`default_nettype none

module bmp_pixel_stream_unpacker (
   input  wire logic clock,
   input  wire logic reset,
   bpsu_req_if.sink   req_ch,
   bpsu_rsp_if.source rsp_ch,
   bpsu_csr_if.sink   csr_ch
);

   import bpsu_pkg::*;

   // configuration registers
   logic [DIM_W-1:0]    image_width_ff;
   logic                mirror_x_ff;
   logic [DIM_W-1:0]    image_height_ff;
   logic                bottom_up_ff;
   logic                has_alpha_ff;
   logic [ORIGIN_W-1:0] origin_x_ff;
   logic [ORIGIN_W-1:0] origin_y_ff;

   // unpacker state
   phase_type          byte_phase_ff, byte_phase_in;
   logic [BYTE_W-1:0]  blue_hold_ff, blue_hold_in;
   logic [BYTE_W-1:0]  green_hold_ff, green_hold_in;
   logic [BYTE_W-1:0]  red_hold_ff, red_hold_in;
   logic [CNT_W-1:0]   column_count_ff, column_count_in;
   logic [CNT_W-1:0]   row_count_ff, row_count_in;
   logic [1:0]         pad_left_ff, pad_left_in;

   // output queue
   rsp_item_type       queue_ff [2];
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         count_ff, count_in;

   logic               req_fire, rsp_fire, emit, pixel_last;
   logic [DIM_W-1:0]   width_eff, height_eff;
   logic [DIM_W-1:0]   col_next, row_next;
   logic               row_end, img_end;
   logic [BYTE_W-1:0]  red_val, alpha_val;
   rsp_item_type       item;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= DIM_W'(1);
         mirror_x_ff     <= 1'b0;
         image_height_ff <= DIM_W'(1);
         bottom_up_ff    <= 1'b1;
         has_alpha_ff    <= 1'b0;
         origin_x_ff     <= '0;
         origin_y_ff     <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_ch.data[DIM_W-1:0];
            REG_MIRROR_X:     mirror_x_ff     <= csr_ch.data[0];
            REG_IMAGE_HEIGHT: image_height_ff <= csr_ch.data[DIM_W-1:0];
            REG_BOTTOM_UP:    bottom_up_ff    <= csr_ch.data[0];
            REG_HAS_ALPHA:    has_alpha_ff    <= csr_ch.data[0];
            REG_ORIGIN_X:     origin_x_ff     <= csr_ch.data[ORIGIN_W-1:0];
            REG_ORIGIN_Y:     origin_y_ff     <= csr_ch.data[ORIGIN_W-1:0];
            default: ;
         endcase
      end
   end

   // zero counts as one, anything above the max is the max
   always_comb begin
      if (image_width_ff == '0)
         width_eff = DIM_W'(1);
      else if (image_width_ff > DIM_W'(MAX_DIM))
         width_eff = DIM_W'(MAX_DIM);
      else
         width_eff = image_width_ff;

      if (image_height_ff == '0)
         height_eff = DIM_W'(1);
      else if (image_height_ff > DIM_W'(MAX_DIM))
         height_eff = DIM_W'(MAX_DIM);
      else
         height_eff = image_height_ff;
   end

   assign req_ch.ready = (count_ff != 2'd2);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_fire     = rsp_ch.valid && rsp_ch.ready;

   assign pixel_last = has_alpha_ff ? (byte_phase_ff == PH_ALPHA)
                                    : (byte_phase_ff inside {PH_RED, PH_ALPHA});
   assign col_next   = {1'b0, column_count_ff} + DIM_W'(1);
   assign row_next   = {1'b0, row_count_ff} + DIM_W'(1);
   assign row_end    = (col_next >= width_eff);
   assign img_end    = (row_next >= height_eff);
   assign red_val    = has_alpha_ff ? red_hold_ff : req_ch.pixel_byte;
   assign alpha_val  = has_alpha_ff ? req_ch.pixel_byte : '0;

   always_comb begin
      item.pixel_color = {alpha_val, red_val, green_hold_ff, blue_hold_ff};
      item.pos_x = mirror_x_ff
         ? (width_eff - DIM_W'(1) - {1'b0, column_count_ff} + {1'b0, origin_x_ff})
         : ({1'b0, column_count_ff} + {1'b0, origin_x_ff});
      item.pos_y = bottom_up_ff
         ? (height_eff - DIM_W'(1) - {1'b0, row_count_ff} + {1'b0, origin_y_ff})
         : ({1'b0, row_count_ff} + {1'b0, origin_y_ff});
      item.image_done = row_end && img_end;
   end

   always_comb begin
      byte_phase_in   = byte_phase_ff;
      blue_hold_in    = blue_hold_ff;
      green_hold_in   = green_hold_ff;
      red_hold_in     = red_hold_ff;
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      pad_left_in     = pad_left_ff;
      emit            = 1'b0;

      if (req_fire) begin
         if (pad_left_ff != 2'd0) begin
            pad_left_in = pad_left_ff - 2'd1;
         end else if (!pixel_last) begin
            case (byte_phase_ff)
               PH_BLUE:  blue_hold_in  = req_ch.pixel_byte;
               PH_GREEN: green_hold_in = req_ch.pixel_byte;
               default:  red_hold_in   = req_ch.pixel_byte;
            endcase
            byte_phase_in = phase_type'(byte_phase_ff + 2'd1);
         end else begin
            emit          = 1'b1;
            byte_phase_in = PH_BLUE;
            if (!has_alpha_ff)
               red_hold_in = req_ch.pixel_byte;
            if (row_end) begin
               column_count_in = '0;
               // 3*w bytes per row padded to 4: pad count equals w mod 4
               pad_left_in     = has_alpha_ff ? 2'd0 : width_eff[1:0];
               row_count_in    = img_end ? '0 : row_next[CNT_W-1:0];
            end else begin
               column_count_in = col_next[CNT_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_phase_ff   <= PH_BLUE;
         blue_hold_ff    <= '0;
         green_hold_ff   <= '0;
         red_hold_ff     <= '0;
         column_count_ff <= '0;
         row_count_ff    <= '0;
         pad_left_ff     <= '0;
      end else begin
         byte_phase_ff   <= byte_phase_in;
         blue_hold_ff    <= blue_hold_in;
         green_hold_ff   <= green_hold_in;
         red_hold_ff     <= red_hold_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         pad_left_ff     <= pad_left_in;
      end
   end

   // two-entry output queue
   always_comb begin
      count_in = count_ff;
      if (emit && !rsp_fire)
         count_in = count_ff + 2'd1;
      else if (!emit && rsp_fire)
         count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (emit)
            wr_ptr_ff <= ~wr_ptr_ff;
         if (rsp_fire)
            rd_ptr_ff <= ~rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (emit)
         queue_ff[wr_ptr_ff] <= item;
   end

   assign rsp_ch.valid       = (count_ff != 2'd0);
   assign rsp_ch.pos_x       = queue_ff[rd_ptr_ff].pos_x;
   assign rsp_ch.pos_y       = queue_ff[rd_ptr_ff].pos_y;
   assign rsp_ch.pixel_color = queue_ff[rd_ptr_ff].pixel_color;
   assign rsp_ch.image_done  = queue_ff[rd_ptr_ff].image_done;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output queue count out of range");

   a_pad_at_pixel_start: assert property (@(posedge clock) disable iff (reset)
      pad_left_ff != 2'd0 |-> byte_phase_ff == PH_BLUE)
      else $error("padding pending in the middle of a pixel");

   a_done_wraps: assert property (@(posedge clock) disable iff (reset)
      emit && item.image_done |=> column_count_ff == '0 && row_count_ff == '0)
      else $error("counters not cleared after the last pixel");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      emit && !rsp_fire |=> count_ff == $past(count_ff) + 2'd1)
      else $error("result not queued");

endmodule

`default_nettype wire
